// ===== rtl/fbf_pkg.sv =====
package fbf_pkg;

  localparam int DIM_DEFAULT       = 2;
  localparam int MAX_TERMS_DEFAULT = 64;
  localparam int COS_BITS_DEFAULT  = 10;

  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 25;
  localparam int ORDER_W   = 3;
  localparam int FEATURE_W = 18;
  localparam int INDEX_W   = 6;
  localparam int PHASE_W   = 17;
  localparam int PROD_W    = 43;
  localparam int QVAL_W    = 35;
  localparam int COUNT_W   = 14;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_DEFAULT = 25'd256;
  localparam logic [63:0]        PI_Q30        = 64'd3373259426;

  localparam logic signed [QVAL_W-1:0] Q_MAX = 35'sd131071;
  localparam logic signed [QVAL_W-1:0] Q_MIN = -35'sd131072;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_LOWER_0 = 3'd0;
  localparam logic [2:0] REG_LOWER_1 = 3'd1;
  localparam logic [2:0] REG_SCALE_0 = 3'd2;
  localparam logic [2:0] REG_SCALE_1 = 3'd3;
  localparam logic [2:0] REG_I_ORDER = 3'd4;
  localparam logic [2:0] REG_D_ORDER = 3'd5;

  // Quarter-wave cosine entry k of a table with 2^bits steps, Q16.
  // Evaluated only at elaboration.
  function automatic logic signed [FEATURE_W-1:0] cos_entry(input int k, input int bits);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    theta = (PI_Q30 * 64'(k)) >> (bits + 1);
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = 64'sd1 <<< 30;
    for (int n = 1; n <= 12; n++) begin
      term = (term * t2) >> 30;
      term = term / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    rnd = (sum + 64'sd8192) >>> 14;
    return rnd[FEATURE_W-1:0];
  endfunction

endpackage

// ===== rtl/fourier_basis_feature_generator.sv =====
// Channel   Handshake             Word
// --------  --------------------  ---------------------------------------------
// input     in_valid / in_stall   sample_0, sample_1
// output    out_valid / out_stall feature, term_index, last, truncated
// config    APB write/read        lower bounds, scales, orders (byte addr 4*i)
//
// An input word is taken only while the row sequencer is idle. The samples
// are normalized first (one multiply, then rounding and term counting), and
// the sequencer then issues one feature row per cycle, while the output is not
// stalled, into a four-stage pipeline (phase, table address, table read,
// sign/output register). An item holds the sequencer until all R of its
// feature rows (R at most MAX_TERMS) are issued, so the next input word is
// not taken before the last row of the previous one. Reset clears control
// state and the configuration registers to their reset values. A stall
// on the output freezes every stage at once, so nothing is lost or repeated.
module fourier_basis_feature_generator #(
  parameter int DIM            = fbf_pkg::DIM_DEFAULT,
  parameter int MAX_TERMS      = fbf_pkg::MAX_TERMS_DEFAULT,
  parameter int COS_TABLE_BITS = fbf_pkg::COS_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fbf_pkg::SAMPLE_W-1:0]    sample_0,
  input  logic signed [fbf_pkg::SAMPLE_W-1:0]    sample_1,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fbf_pkg::FEATURE_W-1:0]   feature,
  output logic [fbf_pkg::INDEX_W-1:0]            term_index,
  output logic                                   last,
  output logic                                   truncated,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [fbf_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [fbf_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [fbf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int N     = 1 << COS_TABLE_BITS;
  localparam int AW    = COS_TABLE_BITS + 1;
  localparam int NW    = $clog2(MAX_TERMS + 1);
  localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PW    = fbf_pkg::PHASE_W;
  localparam int FW    = fbf_pkg::FEATURE_W;
  localparam int OW    = fbf_pkg::ORDER_W;
  localparam int CW    = fbf_pkg::COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_WALK} state_t;

  // Configuration registers.
  logic signed [fbf_pkg::SAMPLE_W-1:0] lower_bound_0, lower_bound_1;
  logic [fbf_pkg::SCALE_W-1:0]         scale_0, scale_1;
  logic [OW-1:0]                       independent_order, dependent_order;

  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound_0     <= '0;
      lower_bound_1     <= '0;
      scale_0           <= fbf_pkg::SCALE_DEFAULT;
      scale_1           <= fbf_pkg::SCALE_DEFAULT;
      independent_order <= '0;
      dependent_order   <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        fbf_pkg::REG_LOWER_0: lower_bound_0     <= pwdata[15:0];
        fbf_pkg::REG_LOWER_1: lower_bound_1     <= pwdata[15:0];
        fbf_pkg::REG_SCALE_0: scale_0           <= pwdata[24:0];
        fbf_pkg::REG_SCALE_1: scale_1           <= pwdata[24:0];
        fbf_pkg::REG_I_ORDER: independent_order <= pwdata[2:0];
        fbf_pkg::REG_D_ORDER: dependent_order   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      fbf_pkg::REG_LOWER_0: prdata = 32'($signed(lower_bound_0));
      fbf_pkg::REG_LOWER_1: prdata = 32'($signed(lower_bound_1));
      fbf_pkg::REG_SCALE_0: prdata = 32'(scale_0);
      fbf_pkg::REG_SCALE_1: prdata = 32'(scale_1);
      fbf_pkg::REG_I_ORDER: prdata = 32'(independent_order);
      fbf_pkg::REG_D_ORDER: prdata = 32'(dependent_order);
      default:              prdata = '0;
    endcase
  end

  // Pipeline advance: every stage moves unless the output word is held.
  logic en;
  assign en = !out_valid || !out_stall;

  state_t state;
  assign in_stall = (state != S_IDLE);

  // Normalization product per dimension; dimensions past the second see a
  // zero sample, zero lower bound and the default scale.
  logic signed [fbf_pkg::PROD_W-1:0] prod_next [DIM];
  logic signed [fbf_pkg::PROD_W-1:0] prod [DIM];

  always_comb begin
    for (int d = 0; d < DIM; d++) begin
      logic signed [16:0] diff;
      logic [fbf_pkg::SCALE_W-1:0] sc;
      if (d == 0) begin
        diff = 17'(sample_0) - 17'(lower_bound_0);
        sc   = scale_0;
      end else if (d == 1) begin
        diff = 17'(sample_1) - 17'(lower_bound_1);
        sc   = scale_1;
      end else begin
        diff = '0;
        sc   = fbf_pkg::SCALE_DEFAULT;
      end
      prod_next[d] = fbf_pkg::PROD_W'(diff) * $signed({18'd0, sc});
    end
  end

  // Rounded Q16 value, saturated copy and the phase-wrapped copy.
  logic signed [FW-1:0] nsat_next [DIM];
  logic [PW-1:0]        wrap_next [DIM];
  logic signed [FW-1:0] nsat [DIM];
  logic [PW-1:0]        wrap [DIM];

  always_comb begin
    for (int d = 0; d < DIM; d++) begin
      logic signed [fbf_pkg::PROD_W-1:0] r;
      logic signed [fbf_pkg::QVAL_W-1:0] q;
      r = (prod[d] + fbf_pkg::PROD_W'(128)) >>> 8;
      q = r[fbf_pkg::QVAL_W-1:0];
      if (q > fbf_pkg::Q_MAX) begin
        nsat_next[d] = fbf_pkg::Q_MAX[FW-1:0];
      end else if (q < fbf_pkg::Q_MIN) begin
        nsat_next[d] = fbf_pkg::Q_MIN[FW-1:0];
      end else begin
        nsat_next[d] = q[FW-1:0];
      end
      wrap_next[d] = q[PW-1:0];
    end
  end

  // Row counts of the latched orders.
  logic [OW-1:0] dord, iord;
  logic [CW-1:0] dterms_next, total_next, limit_next;
  logic          pass_next;

  always_comb begin
    dterms_next = CW'(1);
    for (int d = 0; d < DIM; d++) begin
      dterms_next = CW'(dterms_next * CW'({1'b0, dord} + 4'd1));
    end
    total_next = dterms_next;
    if (iord > dord) begin
      total_next = dterms_next + CW'(CW'(iord - dord) * CW'(DIM));
    end
    pass_next  = (iord == '0) && (dord == '0);
    if (pass_next) begin
      limit_next = CW'(DIM);
    end else if (total_next > CW'(MAX_TERMS)) begin
      limit_next = CW'(MAX_TERMS);
    end else begin
      limit_next = total_next;
    end
  end

  // Row sequencer registers.
  logic [CW-1:0] dterms, dcnt;
  logic [NW-1:0] limit, n;
  logic          pass_mode, trunc;
  logic [OW-1:0] digits [DIM];
  logic [OW-1:0] digits_next [DIM];
  logic [DW-1:0] idim;
  logic [OW-1:0] jord;

  // Stage 1: phase of the row.
  logic          s1_valid, s1_pass, s1_last, s1_trunc;
  logic [PW-1:0] s1_phase;
  logic signed [FW-1:0] s1_value;
  logic [NW-1:0] s1_idx;

  logic [PW-1:0] phase_next;
  logic          row_last;

  always_comb begin
    phase_next = '0;
    if (dcnt < dterms) begin
      for (int d = 0; d < DIM; d++) begin
        phase_next = PW'(phase_next + PW'(digits[d] * wrap[d]));
      end
    end else begin
      phase_next = PW'(jord * wrap[idim]);
    end
    // Mixed-radix increment with digit 0 fastest.
    for (int d = 0; d < DIM; d++) begin
      digits_next[d] = digits[d];
    end
    begin
      logic carry;
      carry = 1'b1;
      for (int d = 0; d < DIM; d++) begin
        if (carry) begin
          if (digits[d] < dord) begin
            digits_next[d] = digits[d] + OW'(1);
            carry          = 1'b0;
          end else begin
            digits_next[d] = '0;
          end
        end
      end
    end
    row_last = (n == limit - NW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s1_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            prod  <= prod_next;
            dord  <= dependent_order;
            iord  <= independent_order;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          nsat      <= nsat_next;
          wrap      <= wrap_next;
          dterms    <= dterms_next;
          limit     <= limit_next[NW-1:0];
          pass_mode <= pass_next;
          trunc     <= !pass_next && (total_next > CW'(MAX_TERMS));
          dcnt      <= '0;
          n         <= '0;
          idim      <= '0;
          jord      <= dord + OW'(1);
          for (int d = 0; d < DIM; d++) begin
            digits[d] <= '0;
          end
          state <= S_WALK;
        end
        S_WALK: begin
          if (en) begin
            s1_valid <= 1'b1;
            s1_pass  <= pass_mode;
            s1_value <= nsat[idim];
            s1_phase <= phase_next;
            s1_idx   <= n;
            s1_last  <= row_last;
            s1_trunc <= trunc;
            n        <= n + NW'(1);
            if (pass_mode) begin
              idim <= idim + DW'(1);
            end else if (dcnt < dterms) begin
              dcnt   <= dcnt + CW'(1);
              digits <= digits_next;
            end else if (jord == iord) begin
              idim <= idim + DW'(1);
              jord <= dord + OW'(1);
            end else begin
              jord <= jord + OW'(1);
            end
            if (row_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (en && state != S_WALK) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage 2: quadrant split and table address.
  logic          s2_valid, s2_pass, s2_last, s2_trunc, s2_neg;
  logic [AW-1:0] s2_addr;
  logic signed [FW-1:0] s2_value;
  logic [NW-1:0] s2_idx;

  logic [1:0]    quad;
  logic [15:0]   rsum;
  logic [AW-1:0] tidx;
  assign quad = s1_phase[16:15];
  assign rsum = {1'b0, s1_phase[14:0]} + 16'(1 << (14 - COS_TABLE_BITS));
  assign tidx = AW'(rsum >> (15 - COS_TABLE_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_addr  <= quad[0] ? AW'(N) - tidx : tidx;
      s2_neg   <= (quad == 2'd1) || (quad == 2'd2);
      s2_pass  <= s1_pass;
      s2_value <= s1_value;
      s2_idx   <= s1_idx;
      s2_last  <= s1_last;
      s2_trunc <= s1_trunc;
    end
  end

  // Stage 3: quarter-wave table read.
  logic signed [FW-1:0] cos_rom [N+1];
  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam logic signed [FW-1:0] Entry = fbf_pkg::cos_entry(k, COS_TABLE_BITS);
    assign cos_rom[k] = Entry;
  end

  logic          s3_valid, s3_pass, s3_last, s3_trunc, s3_neg;
  logic signed [FW-1:0] s3_rom, s3_value;
  logic [NW-1:0] s3_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rom   <= cos_rom[s2_addr];
      s3_neg   <= s2_neg;
      s3_pass  <= s2_pass;
      s3_value <= s2_value;
      s3_idx   <= s2_idx;
      s3_last  <= s2_last;
      s3_trunc <= s2_trunc;
    end
  end

  // Stage 4: sign and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_pass) begin
        feature <= s3_value;
      end else begin
        feature <= s3_neg ? -s3_rom : s3_rom;
      end
      term_index <= fbf_pkg::INDEX_W'(s3_idx);
      last       <= s3_last;
      truncated  <= s3_trunc;
    end
  end

endmodule
